>>> sv/hss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hss_pkg - shared definitions for the hazard scoreboard
// Widths, opcodes, instruction kinds, stage codes, slot entry and lane types.
// ----------------------------------------------------------------------------
package hss_pkg;

  localparam int MAX_WIDTH   = 8;   // slots per stage
  localparam int MAX_DEPS    = 4;
  localparam int NUM_STAGES  = 4;
  localparam int DEP_FIELDS  = 4;
  localparam int DEP_LIMIT   = (MAX_DEPS < DEP_FIELDS) ? MAX_DEPS : DEP_FIELDS;

  localparam int OP_W        = 3;
  localparam int STAGE_W     = 2;
  localparam int SLOT_W      = 3;
  localparam int KIND_W      = 3;
  localparam int ADDR_W      = 32;
  localparam int DCNT_W      = 3;
  localparam int WIDTH_W     = 4;   // pipeline_width register
  localparam int OCC_W       = 4;   // occupancy field
  localparam int CNT_W       = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W       = (CNT_W > WIDTH_W) ? CNT_W : WIDTH_W;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(4);

  // opcodes
  localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE  = 3'd1;
  localparam logic [OP_W-1:0] OP_MARK    = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd3;
  localparam logic [OP_W-1:0] OP_Q_FETCH = 3'd4;
  localparam logic [OP_W-1:0] OP_Q_DEC   = 3'd5;
  localparam logic [OP_W-1:0] OP_Q_EXEC  = 3'd6;
  localparam logic [OP_W-1:0] OP_Q_MEM   = 3'd7;

  // instruction kinds
  localparam logic [KIND_W-1:0] K_INT    = 3'd0;
  localparam logic [KIND_W-1:0] K_FLOAT  = 3'd1;
  localparam logic [KIND_W-1:0] K_BRANCH = 3'd2;
  localparam logic [KIND_W-1:0] K_LOAD   = 3'd3;
  localparam logic [KIND_W-1:0] K_STORE  = 3'd4;

  // stages
  localparam logic [STAGE_W-1:0] ST_FETCH  = 2'd0;
  localparam logic [STAGE_W-1:0] ST_DECODE = 2'd1;
  localparam logic [STAGE_W-1:0] ST_EXEC   = 2'd2;
  localparam logic [STAGE_W-1:0] ST_MEM    = 2'd3;

  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] address;
    logic              done;
  } entry_t;

  // per-lane hazard findings
  typedef struct packed {
    logic fetch_block;  // branch in fetch/decode, or pending branch in execute
    logic exe_same;     // same-kind compute unit busy
    logic dep_block;    // dependency on an unfinished producer
    logic mem_same;     // same-kind load/store in memory
  } lane_flags_t;

  function automatic logic is_compute(input logic [KIND_W-1:0] k);
    return (k == K_INT) || (k == K_FLOAT) || (k == K_BRANCH);
  endfunction

  function automatic logic is_mem(input logic [KIND_W-1:0] k);
    return (k == K_LOAD) || (k == K_STORE);
  endfunction

endpackage

>>> sv/hss_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hss_if - request and response channels
// Valid/ready channels carrying a scoreboard request and its response.
// ----------------------------------------------------------------------------
interface hss_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [hss_pkg::OP_W-1:0]      op;
  logic [hss_pkg::STAGE_W-1:0]   stage;
  logic [hss_pkg::SLOT_W-1:0]    slot;
  logic [hss_pkg::KIND_W-1:0]    kind;
  logic [hss_pkg::ADDR_W-1:0]    address;
  logic [hss_pkg::DCNT_W-1:0]    dep_count;
  logic [hss_pkg::ADDR_W-1:0]    dep_a;
  logic [hss_pkg::ADDR_W-1:0]    dep_b;
  logic [hss_pkg::ADDR_W-1:0]    dep_c;
  logic [hss_pkg::ADDR_W-1:0]    dep_d;

  modport source (
    output valid, op, stage, slot, kind, address, dep_count, dep_a, dep_b, dep_c, dep_d,
    input  ready
  );
  modport sink (
    input  valid, op, stage, slot, kind, address, dep_count, dep_a, dep_b, dep_c, dep_d,
    output ready
  );
endinterface

interface hss_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        allowed;
  logic [hss_pkg::OCC_W-1:0]   occupancy;

  modport source (output valid, allowed, occupancy, input ready);
  modport sink   (input valid, allowed, occupancy, output ready);
endinterface

>>> sv/hss_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hss_lane - hazard checks for one slot position
// Looks at the same slot index in all four stages and flags hazards.
// ----------------------------------------------------------------------------
module hss_lane (
  input  hss_pkg::entry_t [hss_pkg::NUM_STAGES-1:0]               ent,
  input  logic [hss_pkg::KIND_W-1:0]                              qkind,
  input  logic [hss_pkg::DEP_FIELDS-1:0][hss_pkg::ADDR_W-1:0]     deps,
  input  logic [hss_pkg::DEP_FIELDS-1:0]                          dep_en,
  output hss_pkg::lane_flags_t                                    flags
);
  import hss_pkg::*;

  entry_t f, d, e, m;
  logic   exe_prod;   // execute entry that a consumer must wait on
  logic   mem_prod;

  always_comb begin
    f = ent[ST_FETCH];
    d = ent[ST_DECODE];
    e = ent[ST_EXEC];
    m = ent[ST_MEM];

    exe_prod = e.valid && ((!e.done && (e.kind == K_INT || e.kind == K_FLOAT)) ||
                           is_mem(e.kind));
    mem_prod = m.valid && is_mem(m.kind);

    flags.fetch_block = (f.valid && f.kind == K_BRANCH) ||
                        (d.valid && d.kind == K_BRANCH) ||
                        (e.valid && e.kind == K_BRANCH && !e.done);
    flags.exe_same    = e.valid && (e.kind == qkind) && !e.done && is_compute(qkind);
    flags.mem_same    = m.valid && (m.kind == qkind) && is_mem(qkind);

    flags.dep_block = 1'b0;
    for (int j = 0; j < DEP_FIELDS; j++) begin
      if (dep_en[j] && ((exe_prod && e.address == deps[j]) ||
                        (mem_prod && m.address == deps[j])))
        flags.dep_block = 1'b1;
    end
  end

endmodule

>>> sv/hss_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hss_merge - combine lane findings into the answer
// ORs lane hazards, counts the selected stage and applies the stage rule.
// ----------------------------------------------------------------------------
module hss_merge (
  input  hss_pkg::lane_flags_t [hss_pkg::MAX_WIDTH-1:0] flags,
  input  logic [hss_pkg::MAX_WIDTH-1:0]                 row_valid,
  input  logic [hss_pkg::OP_W-1:0]                      op,
  input  logic [hss_pkg::WIDTH_W-1:0]                   pipeline_width,
  output logic                                          allowed,
  output logic [hss_pkg::OCC_W-1:0]                     occupancy
);
  import hss_pkg::*;

  logic [CNT_W-1:0] count;
  logic             full;
  logic             any_fetch, any_exe, any_dep, any_mem;

  always_comb begin
    count     = '0;
    any_fetch = 1'b0;
    any_exe   = 1'b0;
    any_dep   = 1'b0;
    any_mem   = 1'b0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      count     = count + CNT_W'(row_valid[i]);
      any_fetch = any_fetch | flags[i].fetch_block;
      any_exe   = any_exe   | flags[i].exe_same;
      any_dep   = any_dep   | flags[i].dep_block;
      any_mem   = any_mem   | flags[i].mem_same;
    end

    full      = CMP_W'(count) >= CMP_W'(pipeline_width);
    occupancy = OCC_W'(count);

    unique case (op)
      OP_Q_FETCH: allowed = !full && !any_fetch;
      OP_Q_DEC:   allowed = !full;
      OP_Q_EXEC:  allowed = !full && !any_exe && !any_dep;
      OP_Q_MEM:   allowed = !full && !any_mem;
      default:    allowed = 1'b0;
    endcase
  end

endmodule

>>> sv/superscalar_hazard_scoreboard_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// superscalar_hazard_scoreboard_top - pipeline hazard scoreboard
// Slot tables for fetch/decode/execute/memory with stall/proceed queries.
// ----------------------------------------------------------------------------
// Each request is accepted, the slot tables update and the response is
// registered at the same edge, so a new request may follow every cycle while
// the response register is free or being drained. The cycle is set by the
// lane compare (8 lanes, each checking four 32-bit dependency addresses
// against its execute and memory slot) feeding an OR tree and an 8-input
// population count in the merge stage. Update requests (insert, remove, mark
// executed, clear stage) answer allowed = 0 and the stage occupancy after the
// update; queries answer the rule result and the queried stage occupancy.
// The user must write pipeline_width through cfg_we / cfg_wdata only while
// no request is in flight; the block does not enforce this. Width zero stalls
// all queries. There is no clearing pass: only the valid bits are reset.
// ----------------------------------------------------------------------------
module superscalar_hazard_scoreboard_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [hss_pkg::WIDTH_W-1:0]    cfg_wdata,
  hss_cmd_if.sink                        cmd,
  hss_rsp_if.source                      rsp
);
  import hss_pkg::*;

  // configuration
  logic [WIDTH_W-1:0] pipeline_width;

  // slot tables: valid bits reset, payload written on insert, done set on mark
  logic [NUM_STAGES-1:0][MAX_WIDTH-1:0] slot_valid;
  logic [NUM_STAGES-1:0][MAX_WIDTH-1:0] slot_valid_next;
  logic [KIND_W-1:0]                    slot_kind    [NUM_STAGES][MAX_WIDTH];
  logic [ADDR_W-1:0]                    slot_address [NUM_STAGES][MAX_WIDTH];
  logic                                 slot_done    [NUM_STAGES][MAX_WIDTH];

  // response register
  logic             rsp_valid;
  logic             rsp_allowed;
  logic [OCC_W-1:0] rsp_occupancy;

  logic accept;
  logic is_query;
  logic [STAGE_W-1:0] occ_stage;
  logic [NUM_STAGES-1:0][MAX_WIDTH-1:0] slot_hit;   // addressed slot, in range

  logic [DEP_FIELDS-1:0][ADDR_W-1:0] deps;
  logic [DEP_FIELDS-1:0]             dep_en;

  entry_t      [MAX_WIDTH-1:0][NUM_STAGES-1:0] lane_ent;
  lane_flags_t [MAX_WIDTH-1:0]                 lane_flags;

  logic             merge_allowed;
  logic [OCC_W-1:0] merge_occupancy;

  // Response register parts the two sides: a new request is taken while it is
  // empty or its old response is being taken. Nothing is taken during reset.
  assign cmd.ready = !rst && (!rsp_valid || rsp.ready);
  assign accept    = cmd.valid && cmd.ready;

  assign rsp.valid     = rsp_valid;
  assign rsp.allowed   = rsp_allowed;
  assign rsp.occupancy = rsp_occupancy;

  assign is_query  = (cmd.op >= OP_Q_FETCH);
  // query opcodes are laid out in stage order
  assign occ_stage = is_query ? STAGE_W'(cmd.op - OP_Q_FETCH) : cmd.stage;

  assign deps = {cmd.dep_d, cmd.dep_c, cmd.dep_b, cmd.dep_a};

  // dependency count saturates at the number of usable fields
  always_comb begin
    for (int j = 0; j < DEP_FIELDS; j++)
      dep_en[j] = (int'(cmd.dep_count) > j) && (j < DEP_LIMIT);
  end

  // Slot decode and next valid bits. An out-of-range slot never hits.
  always_comb begin
    for (int s = 0; s < NUM_STAGES; s++) begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
        slot_hit[s][i]        = (int'(cmd.stage) == s) && (int'(cmd.slot) == i);
        slot_valid_next[s][i] = slot_valid[s][i];
        unique case (cmd.op)
          OP_INSERT: if (slot_hit[s][i]) slot_valid_next[s][i] = 1'b1;
          OP_REMOVE: if (slot_hit[s][i]) slot_valid_next[s][i] = 1'b0;
          OP_CLEAR:  if (int'(cmd.stage) == s) slot_valid_next[s][i] = 1'b0;
          default:   ;
        endcase
      end
    end
  end

  // Lane i sees slot i of every stage.
  always_comb begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      for (int s = 0; s < NUM_STAGES; s++) begin
        lane_ent[i][s].valid   = slot_valid[s][i];
        lane_ent[i][s].kind    = slot_kind[s][i];
        lane_ent[i][s].address = slot_address[s][i];
        lane_ent[i][s].done    = slot_done[s][i];
      end
    end
  end

  for (genvar g = 0; g < MAX_WIDTH; g++) begin : g_lane
    hss_lane u_lane (
      .ent    (lane_ent[g]),
      .qkind  (cmd.kind),
      .deps   (deps),
      .dep_en (dep_en),
      .flags  (lane_flags[g])
    );
  end

  // Occupancy comes from the post-update row; queries leave it unchanged,
  // so the same count also drives the full check.
  hss_merge u_merge (
    .flags          (lane_flags),
    .row_valid      (slot_valid_next[occ_stage]),
    .op             (cmd.op),
    .pipeline_width (pipeline_width),
    .allowed        (merge_allowed),
    .occupancy      (merge_occupancy)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pipeline_width <= WIDTH_RESET;
      slot_valid     <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      if (cfg_we)
        pipeline_width <= cfg_wdata;
      if (accept)
        slot_valid <= slot_valid_next;
      if (accept)
        rsp_valid <= 1'b1;
      else if (rsp.ready)
        rsp_valid <= 1'b0;
    end
  end

  // payload: response fields and slot contents
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_allowed   <= merge_allowed;
      rsp_occupancy <= merge_occupancy;
      for (int s = 0; s < NUM_STAGES; s++) begin
        for (int i = 0; i < MAX_WIDTH; i++) begin
          if (slot_hit[s][i] && cmd.op == OP_INSERT) begin
            slot_kind[s][i]    <= cmd.kind;
            slot_address[s][i] <= cmd.address;
            slot_done[s][i]    <= 1'b0;
          end else if (slot_hit[s][i] && cmd.op == OP_MARK) begin
            slot_done[s][i]    <= 1'b1;   // set even on an empty slot
          end
        end
      end
    end
  end

endmodule
